[rtl/core/rfc3339_timestamp_to_epoch_ns_top_assert.svh]
// Assertion macros for the timestamp-to-epoch block.
// Used by the top level; relies on clk and rst being in scope.
`ifndef RFC3339_TIMESTAMP_TO_EPOCH_NS_TOP_ASSERT_SVH
`define RFC3339_TIMESTAMP_TO_EPOCH_NS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rfc_ts_pkg.sv]
// Shared types, constants and small functions for the timestamp-to-epoch block.
// No dependencies.
package rfc_ts_pkg;

  // Channel payloads
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic [62:0] epoch_ns;
    logic        parse_ok;
  } ts_item_t;

  // Parsed fields of one text, handed from parser to converter
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] frac;
    logic [3:0]  frac_count;
    logic        ok;
  } ts_fields_t;

  localparam int unsigned FRAC_DIGITS_DEF = 9;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [4:0]  DATE_LEN    = 5'd19;
  localparam logic [4:0]  POS_FRAC    = 5'd19;
  localparam logic [4:0]  POS_PAST    = 5'd20;
  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [11:0] LEAPS_1969  = 12'd477;
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // Reciprocal for division by 100 on 14-bit values
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Days before the first of the month (non-leap year)
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Padding factor for a fraction
  function automatic logic [29:0] pow10(input logic [3:0] k);
    logic [29:0] p;
    case (k)
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/rfc_ts_front.sv]
// Character parser: checks the date-time form and collects fields.
// Depends on rfc_ts_pkg; pushes one field record per text into the queue.
module rfc_ts_front #(
  parameter int unsigned FRACTION_DIGITS = rfc_ts_pkg::FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  rfc_ts_pkg::char_item_t  char_data,
  input  logic                    q_full,
  output logic                    q_push,
  output rfc_ts_pkg::ts_fields_t  q_rec
);
  import rfc_ts_pkg::*;

  localparam logic [3:0] FD_MAX = 4'(FRACTION_DIGITS);

  logic [4:0]  pos,      pos_next;
  logic [13:0] year,     year_next;
  logic [3:0]  month,    month_next;
  logic [4:0]  day,      day_next;
  logic [4:0]  hour,     hour_next;
  logic [5:0]  minute,   minute_next;
  logic [5:0]  second,   second_next;
  logic [29:0] frac,     frac_next;
  logic [3:0]  fcount,   fcount_next;
  logic        factive,  factive_next;
  logic        fclosed,  fclosed_next;
  logic        fmt_err,  fmt_err_next;

  logic [7:0]  c;
  logic        dig;
  logic [3:0]  d;
  logic [6:0]  two_val;
  logic [17:0] year_mac;
  logic [33:0] frac_mac;
  logic        accept;

  assign c          = char_data.char_code;
  assign dig        = is_digit(c);
  assign d          = c[3:0];
  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;
  assign q_push     = accept && char_data.last_char;

  // Next parser state for the current character
  always_comb begin
    pos_next     = (pos < POS_PAST) ? pos + 5'd1 : pos;
    year_next    = year;
    month_next   = month;
    day_next     = day;
    hour_next    = hour;
    minute_next  = minute;
    second_next  = second;
    frac_next    = frac;
    fcount_next  = fcount;
    factive_next = factive;
    fclosed_next = fclosed;
    fmt_err_next = fmt_err;
    year_mac     = 18'(year) * 18'd10 + 18'(d);
    frac_mac     = 34'(frac) * 34'd10 + 34'(d);
    two_val      = 7'd0;

    unique case (pos) inside
      [5'd0:5'd3]: begin
        if (dig) year_next = year_mac[13:0];
        else fmt_err_next = 1'b1;
      end
      5'd4, 5'd7: begin
        if (c != CH_DASH) fmt_err_next = 1'b1;
      end
      5'd10: begin
        if (c != CH_T) fmt_err_next = 1'b1;
      end
      5'd13, 5'd16: begin
        if (c != CH_COLON) fmt_err_next = 1'b1;
      end
      5'd5, 5'd8, 5'd11, 5'd14, 5'd17: begin
        // tens digit of a two-digit field
        if (!dig) fmt_err_next = 1'b1;
        else begin
          case (pos)
            5'd5:    month_next  = d;
            5'd8:    day_next    = 5'(d);
            5'd11:   hour_next   = 5'(d);
            5'd14:   minute_next = 6'(d);
            default: second_next = 6'(d);
          endcase
        end
      end
      5'd6: begin
        two_val = 7'(month) * 7'd10 + 7'(d);
        if (!dig || two_val < 7'd1 || two_val > 7'd12) fmt_err_next = 1'b1;
        else month_next = two_val[3:0];
      end
      5'd9: begin
        two_val = 7'(day) * 7'd10 + 7'(d);
        if (!dig || two_val < 7'd1 || two_val > 7'd31) fmt_err_next = 1'b1;
        else day_next = two_val[4:0];
      end
      5'd12: begin
        two_val = 7'(hour) * 7'd10 + 7'(d);
        if (!dig || two_val > 7'd23) fmt_err_next = 1'b1;
        else hour_next = two_val[4:0];
      end
      5'd15: begin
        two_val = 7'(minute) * 7'd10 + 7'(d);
        if (!dig || two_val > 7'd59) fmt_err_next = 1'b1;
        else minute_next = two_val[5:0];
      end
      5'd18: begin
        two_val = 7'(second) * 7'd10 + 7'(d);
        if (!dig || two_val > 7'd60) fmt_err_next = 1'b1;
        else second_next = two_val[5:0];
      end
      POS_FRAC: begin
        if (c == CH_DOT) factive_next = 1'b1;
        else fclosed_next = 1'b1;
      end
      default: begin
        // fraction digits; anything after the fraction is ignored
        if (factive && !fclosed) begin
          if (dig && fcount < FD_MAX) begin
            frac_next   = frac_mac[29:0];
            fcount_next = fcount + 4'd1;
            if (fcount + 4'd1 >= FD_MAX) fclosed_next = 1'b1;
          end else begin
            fclosed_next = 1'b1;
          end
        end
      end
    endcase
  end

  // Field record for the converter, taken from the post-character state
  always_comb begin
    q_rec.year       = year_next;
    q_rec.month      = month_next;
    q_rec.day        = day_next;
    q_rec.hour       = hour_next;
    q_rec.minute     = minute_next;
    q_rec.second     = second_next;
    q_rec.frac       = frac_next;
    q_rec.frac_count = fcount_next;
    q_rec.ok         = (pos_next >= DATE_LEN) && !fmt_err_next &&
                       (year_next >= EPOCH_YEAR);
  end

  // Parser state; cleared at the end of each text
  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      pos     <= '0;
      year    <= '0;
      month   <= '0;
      day     <= '0;
      hour    <= '0;
      minute  <= '0;
      second  <= '0;
      frac    <= '0;
      fcount  <= '0;
      factive <= 1'b0;
      fclosed <= 1'b0;
      fmt_err <= 1'b0;
    end else if (accept) begin
      pos     <= pos_next;
      year    <= year_next;
      month   <= month_next;
      day     <= day_next;
      hour    <= hour_next;
      minute  <= minute_next;
      second  <= second_next;
      frac    <= frac_next;
      fcount  <= fcount_next;
      factive <= factive_next;
      fclosed <= fclosed_next;
      fmt_err <= fmt_err_next;
    end
  end

endmodule

[rtl/core/rfc_ts_queue.sv]
// Short register queue of parsed field records between parser and converter.
// Depends on rfc_ts_pkg.
module rfc_ts_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_push,
  input  rfc_ts_pkg::ts_fields_t  q_rec,
  input  logic                    q_pop,
  output logic                    q_full,
  output logic                    q_empty,
  output rfc_ts_pkg::ts_fields_t  q_head
);
  import rfc_ts_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  ts_fields_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign q_head  = slots[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= q_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

[rtl/core/rfc_ts_back.sv]
// Converter: turns one parsed record into nanoseconds since the epoch.
// Depends on rfc_ts_pkg; a sequencer over eight steps, output register at the end.
module rfc_ts_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  rfc_ts_pkg::ts_fields_t  q_head,
  output logic                    q_pop,
  output logic                    ts_valid,
  input  logic                    ts_ready,
  output rfc_ts_pkg::ts_item_t    ts_data
);
  import rfc_ts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LEAP, S_DAYS, S_SECS, S_MUL_LO, S_MUL_HI, S_SUM
  } state_t;

  state_t      state;
  ts_fields_t  f;
  logic [13:0] ym1;
  logic [7:0]  q100;
  logic [29:0] frac_ns;
  logic        leap;
  logic [11:0] leaps;
  logic [22:0] yr_days;
  logic [22:0] days;
  logic [38:0] secs;
  logic [49:0] plo;
  logic [48:0] phi;

  logic [26:0] div_prod;
  logic [59:0] pad_prod;
  logic [6:0]  rem100;
  logic [7:0]  q100_p1;
  logic [11:0] leaps_calc;
  logic [22:0] yr_days_calc;
  logic [22:0] days_calc;
  logic [39:0] secs_calc;
  logic [69:0] total;
  logic        out_free;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !ts_valid || ts_ready;

  // Step arithmetic for the sequencer states
  always_comb begin
    div_prod     = 27'(ym1) * 27'(DIV100_MUL);
    pad_prod     = 60'(f.frac) * 60'(pow10(4'd9 - f.frac_count));
    rem100       = 7'(ym1 - 14'(q100) * 14'd100);
    q100_p1      = q100 + 8'd1;
    leaps_calc   = 12'(ym1 >> 2) - 12'(q100) + 12'(q100 >> 2) - LEAPS_1969;
    yr_days_calc = 23'(f.year - EPOCH_YEAR) * 23'd365;
    days_calc    = yr_days + 23'(leaps) + 23'(cum_days(f.month)) +
                   23'(leap && (f.month > 4'd2)) + 23'(f.day) - 23'd1;
    secs_calc    = 40'(days) * 40'(SEC_PER_DAY) + 40'(f.hour) * 40'd3600 +
                   40'(f.minute) * 40'd60 + 40'(f.second);
    total        = {1'b0, phi, 20'd0} + 70'(plo) + 70'(frac_ns);
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ts_valid <= 1'b0;
    end else begin
      // drop the item once taken, unless a new one is loaded below
      if (ts_valid && ts_ready && (state != S_SUM)) ts_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            f     <= q_head;
            ym1   <= q_head.year - 14'd1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          q100    <= div_prod[DIV100_SHIFT +: 8];
          frac_ns <= pad_prod[29:0];
          state   <= S_LEAP;
        end
        S_LEAP: begin
          // year divisible by 100 exactly when (year-1) mod 100 is 99
          leap    <= (f.year[1:0] == 2'd0) &&
                     ((rem100 != 7'd99) || (q100_p1[1:0] == 2'd0));
          leaps   <= leaps_calc;
          yr_days <= yr_days_calc;
          state   <= S_DAYS;
        end
        S_DAYS: begin
          days  <= days_calc;
          state <= S_SECS;
        end
        S_SECS: begin
          secs  <= secs_calc[38:0];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          plo   <= 50'(secs[19:0]) * 50'(NS_PER_SEC);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi   <= 49'(secs[38:20]) * 49'(NS_PER_SEC);
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            ts_valid         <= 1'b1;
            ts_data.parse_ok <= f.ok;
            if (!f.ok)                    ts_data.epoch_ns <= '0;
            else if (total[69:63] != '0)  ts_data.epoch_ns <= '1;
            else                          ts_data.epoch_ns <= total[62:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/rfc3339_timestamp_to_epoch_ns_top.sv]
// Timestamp text to epoch nanoseconds. Characters of a YYYY-MM-DDTHH:MM:SS[.fff]
// text enter one per cycle on the char channel; the character flagged last_char
// ends the text and yields exactly one result on the ts channel: epoch_ns
// (saturated at 2^63-1) and parse_ok, with epoch_ns zero when parse_ok is low.
// The parser takes a character every cycle while the record queue has room.
// Each text then holds the converter for the pop in S_IDLE and seven steps,
// the last of which loads the output register once the ts channel is free;
// the converter can work on the next record while a result waits there.
// A 2-entry record queue sits between parser and converter; it fills and
// stalls input when texts arrive faster than the converter finishes them,
// or when the ts channel is held off.
`include "rfc3339_timestamp_to_epoch_ns_top_assert.svh"

module rfc3339_timestamp_to_epoch_ns_top #(
  parameter int unsigned FRACTION_DIGITS = rfc_ts_pkg::FRAC_DIGITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  rfc_ts_pkg::char_item_t  char_data,
  output logic                    ts_valid,
  input  logic                    ts_ready,
  output rfc_ts_pkg::ts_item_t    ts_data
);
  import rfc_ts_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  ts_fields_t q_rec;
  ts_fields_t q_head;

  // Parser
  rfc_ts_front #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_rec)
  );

  // Record queue
  rfc_ts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Converter
  rfc_ts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .ts_valid (ts_valid),
    .ts_ready (ts_ready),
    .ts_data  (ts_data)
  );

  // Checks
  `TS_ASSERT_IMP(a_zero_on_fail, ts_valid && !ts_data.parse_ok, ts_data.epoch_ns == '0, "failed parse gives nonzero epoch")
  `TS_ASSERT_IMP(a_no_push_full, q_push, !q_full, "record pushed into full queue")
  `TS_ASSERT_NEXT(a_push_lands, q_push && q_empty, !q_empty, "pushed record lost")

endmodule

[verif/rfc3339_epoch_ns_monitor.sv]
// Channel monitor for the timestamp-to-epoch block: tracks every character
// taken in, predicts each epoch result, and compares against the output item.
// Depends on rfc_ts_pkg for the payload types and character codes.
module rfc3339_epoch_ns_monitor #(
  parameter int unsigned FRACTION_DIGITS = rfc_ts_pkg::FRAC_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  input  logic                   char_ready,
  input  rfc_ts_pkg::char_item_t char_data,
  input  logic                   ts_valid,
  input  logic                   ts_ready,
  input  rfc_ts_pkg::ts_item_t   ts_data,
  output int                     fail_count,
  output int                     pending_count
);
  import rfc_ts_pkg::*;

  localparam longint unsigned NS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned NS_SEC    = 64'd1_000_000_000;
  localparam int unsigned     NS_DIGITS = 9;
  localparam logic [4:0]      POS_DONE  = 5'd20;
  localparam logic [4:0]      DATE_CHARS = 5'd19;

  // Parse state of the text in flight
  logic [4:0]  pos;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [29:0] frac;
  logic [3:0]  frac_cnt;
  logic        frac_on;
  logic        frac_done;
  logic        bad;

  ts_item_t pending_epochs[$];

  function automatic longint unsigned leap_count(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic logic leap_year(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_before_month(input logic [3:0] m);
    case (m)
      4'd2:    return 31;
      4'd3:    return 59;
      4'd4:    return 90;
      4'd5:    return 120;
      4'd6:    return 151;
      4'd7:    return 181;
      4'd8:    return 212;
      4'd9:    return 243;
      4'd10:   return 273;
      4'd11:   return 304;
      4'd12:   return 334;
      default: return 0;
    endcase
  endfunction

  task automatic clear_text();
    pos = '0; year = '0; month = '0; day = '0; hour = '0; minute = '0;
    second = '0; frac = '0; frac_cnt = '0;
    frac_on = 1'b0; frac_done = 1'b0; bad = 1'b0;
  endtask

  // Absorb one character; on the last one queue the predicted result
  task automatic parse_char(input logic [7:0] c, input logic last);
    logic              num;
    logic              ok;
    int                dig;
    int                pair;
    longint unsigned   yr;
    longint unsigned   days;
    longint unsigned   secs;
    longint unsigned   frac_ns;
    ts_item_t          want;
    num = (c >= CH_ZERO) && (c <= CH_NINE);
    dig = int'(c) - int'(CH_ZERO);
    pair = 0;
    case (pos)
      5'd0, 5'd1, 5'd2, 5'd3: begin
        if (num) year = 14'(int'(year) * 10 + dig);
        else bad = 1'b1;
      end
      5'd4, 5'd7: if (c != CH_DASH) bad = 1'b1;
      5'd10: if (c != CH_T) bad = 1'b1;
      5'd13, 5'd16: if (c != CH_COLON) bad = 1'b1;
      5'd5: if (num) month = 4'(dig); else bad = 1'b1;
      5'd8: if (num) day = 5'(dig); else bad = 1'b1;
      5'd11: if (num) hour = 5'(dig); else bad = 1'b1;
      5'd14: if (num) minute = 6'(dig); else bad = 1'b1;
      5'd17: if (num) second = 6'(dig); else bad = 1'b1;
      // second digit of each pair: range check, tens digit kept on error
      5'd6: begin
        pair = int'(month) * 10 + dig;
        if (!num || pair < 1 || pair > 12) bad = 1'b1; else month = 4'(pair);
      end
      5'd9: begin
        pair = int'(day) * 10 + dig;
        if (!num || pair < 1 || pair > 31) bad = 1'b1; else day = 5'(pair);
      end
      5'd12: begin
        pair = int'(hour) * 10 + dig;
        if (!num || pair > 23) bad = 1'b1; else hour = 5'(pair);
      end
      5'd15: begin
        pair = int'(minute) * 10 + dig;
        if (!num || pair > 59) bad = 1'b1; else minute = 6'(pair);
      end
      5'd18: begin
        pair = int'(second) * 10 + dig;
        if (!num || pair > 60) bad = 1'b1; else second = 6'(pair);
      end
      5'd19: begin
        if (c == CH_DOT) frac_on = 1'b1;
        else frac_done = 1'b1;
      end
      default: begin
        // fraction runs until a non-digit or the digit limit
        if (frac_on && !frac_done) begin
          if (num && frac_cnt < FRACTION_DIGITS) begin
            frac = 30'(int'(frac) * 10 + dig);
            frac_cnt = frac_cnt + 4'd1;
            if (frac_cnt >= FRACTION_DIGITS) frac_done = 1'b1;
          end else begin
            frac_done = 1'b1;
          end
        end
      end
    endcase
    if (pos < POS_DONE) pos = pos + 5'd1;

    if (last) begin
      ok = (pos >= DATE_CHARS) && !bad && (year >= 14'd1970);
      want = '0;
      if (ok) begin
        yr = year;
        days = 365 * (yr - 1970) + leap_count(yr - 1) - leap_count(1969);
        days = days + days_before_month(month) + longint'(day) - 1;
        if (leap_year(yr) && month > 4'd2) days = days + 1;
        secs = days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
             + longint'(second);
        frac_ns = frac;
        for (int k = frac_cnt; k < NS_DIGITS; k++) frac_ns = frac_ns * 10;
        if (secs > (NS_MAX - frac_ns) / NS_SEC) want.epoch_ns = 63'(NS_MAX);
        else want.epoch_ns = 63'(secs * NS_SEC + frac_ns);
        want.parse_ok = 1'b1;
      end
      pending_epochs.push_back(want);
      clear_text();
    end
  endtask

  // Compare results first, then take in characters
  always @(posedge clk) begin
    ts_item_t want;
    if (rst) begin
      clear_text();
      pending_epochs.delete();
    end else begin
      if (ts_valid && ts_ready) begin
        if (pending_epochs.size() == 0) begin
          $display("%0t: unexpected result epoch_ns %0d parse_ok %0b", $time,
                   ts_data.epoch_ns, ts_data.parse_ok);
          fail_count = fail_count + 1;
        end else begin
          want = pending_epochs.pop_front();
          if (ts_data.epoch_ns !== want.epoch_ns) begin
            $display("%0t: epoch_ns expected %0d actual %0d", $time,
                     want.epoch_ns, ts_data.epoch_ns);
            fail_count = fail_count + 1;
          end
          if (ts_data.parse_ok !== want.parse_ok) begin
            $display("%0t: parse_ok expected %0b actual %0b", $time,
                     want.parse_ok, ts_data.parse_ok);
            fail_count = fail_count + 1;
          end
        end
      end
      if (char_valid && char_ready) parse_char(char_data.char_code, char_data.last_char);
    end
    pending_count <= pending_epochs.size();
  end

endmodule

[verif/rfc3339_timestamp_to_epoch_ns_top_tb.sv]
// Testbench top for the timestamp-to-epoch block: clock, reset, text stimulus
// and the verdict. Depends on rfc_ts_pkg, the block and rfc3339_epoch_ns_monitor.
module rfc3339_timestamp_to_epoch_ns_top_tb;
  import rfc_ts_pkg::*;

  localparam int unsigned RANDOM_CHARS = 400;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       ts_ready = 1'b0;
  char_item_t char_data = '0;
  logic       char_ready;
  logic       ts_valid;
  ts_item_t   ts_data;
  int         fail_count;
  int         pending_count;

  logic        steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent_chars = 0;
  int unsigned text_count = 0;
  logic [7:0]  text_q[$];

  rfc3339_timestamp_to_epoch_ns_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .ts_valid   (ts_valid),
    .ts_ready   (ts_ready),
    .ts_data    (ts_data)
  );

  rfc3339_epoch_ns_monitor i_monitor (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .char_data     (char_data),
    .ts_valid      (ts_valid),
    .ts_ready      (ts_ready),
    .ts_data       (ts_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    ts_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rfc3339_timestamp_to_epoch_ns_top verification failed");
      $finish;
    end
  end

  // Text building
  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned v, input int unsigned width);
    int unsigned scale;
    scale = 1;
    repeat (width - 1) scale = scale * 10;
    repeat (width) begin
      text_q.push_back(8'(CH_ZERO + (v / scale) % 10));
      scale = scale / 10;
    end
  endtask

  task automatic add_digits(input int unsigned n);
    repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic add_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                          input int unsigned h, input int unsigned mi, input int unsigned s);
    add_number(y, 4);
    text_q.push_back(CH_DASH);
    add_number(mo, 2);
    text_q.push_back(CH_DASH);
    add_number(d, 2);
    text_q.push_back(CH_T);
    add_number(h, 2);
    text_q.push_back(CH_COLON);
    add_number(mi, 2);
    text_q.push_back(CH_COLON);
    add_number(s, 2);
  endtask

  // Send the built text, last flag on its final character
  task automatic send_text();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
      char_valid <= 1'b1;
      char_data  <= {text_q[i], (i == n - 1) ? 1'b1 : 1'b0};
      @(posedge clk);
      while (!char_ready) @(posedge clk);
      sent_chars = sent_chars + 1;
    end
    text_q.delete();
  endtask

  task automatic send_string(input string s);
    add_string(s);
    send_text();
  endtask

  // Hold the sender until every result is out
  task automatic settle();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic make_random_text();
    int unsigned kind;
    int unsigned yr;
    int unsigned len;
    int unsigned tail;
    int unsigned at;
    kind = $urandom_range(99);
    yr = ($urandom_range(4) == 0) ? $urandom_range(9999) : $urandom_range(2262, 1970);
    if (kind >= 95) begin
      // pure noise
      len = $urandom_range(30, 1);
      repeat (len) text_q.push_back(8'($urandom));
    end else begin
      if (kind >= 65 && kind < 80)
        add_date(yr, $urandom_range(99), $urandom_range(99), $urandom_range(99),
                 $urandom_range(99), $urandom_range(99));
      else
        add_date(yr, $urandom_range(12, 1), $urandom_range(31, 1), $urandom_range(23),
                 $urandom_range(59), $urandom_range(60));
      if (kind >= 90) begin
        // truncated date
        len = $urandom_range(18, 1);
        while (text_q.size() > len) text_q.delete(text_q.size() - 1);
      end else begin
        tail = $urandom_range(3);
        if (tail == 1 || tail == 2) begin
          text_q.push_back(CH_DOT);
          add_digits($urandom_range(12));
        end
        if (tail == 2) begin
          if ($urandom_range(1) == 0) begin
            add_string("Z");
          end else begin
            add_string(($urandom_range(1) == 0) ? "+" : "-");
            add_number($urandom_range(23), 2);
            text_q.push_back(CH_COLON);
            add_number($urandom_range(59), 2);
          end
        end
        if (tail == 3) repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom));
        if (kind >= 80) begin
          // one corrupted byte anywhere
          at = $urandom_range(text_q.size() - 1);
          text_q[at] = 8'($urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: range extremes, calendar corners, fraction handling
    send_string("1970-01-01T00:00:00");
    send_string("1969-12-31T23:59:59.999999999");
    send_string("0000-01-01T00:00:00");
    send_string("9999-12-31T23:59:60.999999999Z");
    send_string("2262-04-11T23:47:16.854775807");
    send_string("2262-04-11T23:47:16.854775808");
    send_string("2000-02-29T12:00:00.5+01:00");
    send_string("2100-03-01T00:00:00");
    send_string("2021-02-31T00:00:00");
    send_string("2024-06-30T23:59:59.1234567891234");
    send_string("2024-06-30T23:59:59.Z");
    send_string("2024-06-30T23:59:59.12a45");
    send_string("2024-06-30T23:59:59Z");
    send_string("2024-06-30T23:59:5");
    send_string("2024-00-10T00:00:00");
    send_string("2024-13-10T00:00:00");
    send_string("2024-01-00T00:00:00");
    send_string("2024-01-32T00:00:00");
    send_string("2024-01-10T24:00:00");
    send_string("2024-01-10T00:60:00");
    send_string("2024-01-10T00:00:61");
    // back-to-back one-character texts
    repeat (5) send_string("7");
    // extreme byte values after the fraction
    add_string("2024-06-30T23:59:59.1");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    // long text, position counter saturates
    add_string("2024-06-30T23:59:59.123+05:30");
    repeat (30) text_q.push_back(8'($urandom));
    send_text();
    // each date position corrupted, digits hit with 0x2F at odd and 0x3A at even positions
    for (int p = 0; p < 19; p++) begin
      add_string("2024-06-30T23:59:59");
      if (p == 4 || p == 7 || p == 10 || p == 13 || p == 16) text_q[p] = CH_ZERO;
      else text_q[p] = (p % 2 == 1) ? 8'h2F : 8'h3A;
      send_text();
    end
    settle();

    // Random texts, with a stretch of no idling and one full drain
    sent_chars = 0;
    while (sent_chars < RANDOM_CHARS) begin
      text_count = text_count + 1;
      steady = (text_count >= 3 && text_count < 11);
      if (text_count == 13) settle();
      make_random_text();
      send_text();
    end
    steady = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("rfc3339_timestamp_to_epoch_ns_top verification clean");
    end else begin
      $display("rfc3339_timestamp_to_epoch_ns_top verification failed");
    end
    $finish;
  end

endmodule
